FILE: src/dfq_pkg.sv
package dfq_pkg;

  localparam int KEY_WIDTH         = 32;
  localparam int QUEUE_DEPTH_DEF   = 16;
  localparam int OCC_W             = 5;
  localparam int STATUS_W          = 2;

  // operation codes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUP   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic                 kind;
    logic [KEY_WIDTH-1:0] key;
  } dfq_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic                 head_valid;
    logic [KEY_WIDTH-1:0] head_key;
    logic [OCC_W-1:0]     occupancy;
  } dfq_out_t;

  // broadcast to every cell
  typedef struct packed {
    logic                 push;
    logic                 pop;
    logic [KEY_WIDTH-1:0] key;
  } dfq_cell_ctrl_t;

  // row summary back to the control
  typedef struct packed {
    logic                 dup;
    logic                 full;
    logic                 head_valid;
    logic [KEY_WIDTH-1:0] head_key;
    logic                 second_valid;
    logic [KEY_WIDTH-1:0] second_key;
  } dfq_row_stat_t;

endpackage

FILE: src/dedup_fifo_queue.sv
// dedup_fifo_queue: a result is registered into the output register, or into the skid
// slot while a result waits there; one operation per cycle while in_stall is low, set by
// the cell row (parallel compare in every cell, shift toward the head on pop)
// a two-slot output (register plus skid) keeps input open while one result waits
// rst_n synchronous active low: queue empty, output slots empty; stored keys not cleared
module dedup_fifo_queue
  import dfq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  dfq_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output dfq_out_t out_data
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // entry count, only needed for occupancy reporting
  logic [CNT_W-1:0] count_r, count_nxt;

  // output register and skid slot
  logic     out_valid_r, out_valid_nxt;
  logic     skid_valid_r, skid_valid_nxt;
  dfq_out_t out_r, out_nxt;
  dfq_out_t skid_r, skid_nxt;

  logic           in_xfer;
  logic           out_xfer;
  logic           do_push;
  logic           do_pop;
  logic [STATUS_W-1:0] status;
  logic           head_valid_nxt;
  logic [KEY_WIDTH-1:0] head_key_nxt;
  logic [CNT_W+OCC_W-1:0] count_ext;
  dfq_out_t       result;
  dfq_cell_ctrl_t ctrl;
  dfq_row_stat_t  stat;

  // input held off only when both output slots are taken
  assign in_stall = skid_valid_r;
  assign in_xfer  = in_valid && !skid_valid_r;
  assign out_xfer = out_valid_r && !out_stall;

  // operation decode; duplicate check wins over full
  always_comb begin
    status  = ST_DONE;
    do_push = 1'b0;
    do_pop  = 1'b0;
    if (in_data.kind == OP_PUSH) begin
      if (stat.dup) begin
        status = ST_DUP;
      end else if (stat.full) begin
        status = ST_FULL;
      end else begin
        do_push = in_xfer;
      end
    end else begin
      if (!stat.head_valid) begin
        status = ST_EMPTY;
      end else begin
        do_pop = in_xfer;
      end
    end
  end

  assign ctrl.push = do_push;
  assign ctrl.pop  = do_pop;
  assign ctrl.key  = in_data.key;

  dfq_row #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_row (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (ctrl),
    .stat  (stat)
  );

  // head as it stands after this operation
  always_comb begin
    if (do_push) begin
      head_valid_nxt = 1'b1;
      head_key_nxt   = stat.head_valid ? stat.head_key : in_data.key;
    end else if (do_pop) begin
      head_valid_nxt = stat.second_valid;
      head_key_nxt   = stat.second_valid ? stat.second_key : '0;
    end else begin
      head_valid_nxt = stat.head_valid;
      head_key_nxt   = stat.head_valid ? stat.head_key : '0;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (do_push) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // occupancy field is the low bits of the count
  assign count_ext = {{OCC_W{1'b0}}, count_nxt};

  assign result.status     = status;
  assign result.head_valid = head_valid_nxt;
  assign result.head_key   = head_key_nxt;
  assign result.occupancy  = count_ext[OCC_W-1:0];

  // output register with skid slot behind it
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      if (out_xfer) begin
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (in_xfer) begin
      if (!out_valid_r || out_xfer) begin
        out_nxt       = result;
        out_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = result;
        skid_valid_nxt = 1'b1;
      end
    end else if (out_xfer) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // payload slots carry no reset
  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTH
  // skid slot only fills behind a waiting result
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("dedup_fifo_queue: skid holds data with output empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("dedup_fifo_queue: count beyond depth");

  // count and head flag of the cell row agree
  a_count_head: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) == !stat.head_valid)
    else $error("dedup_fifo_queue: count disagrees with cell row");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    do_push |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("dedup_fifo_queue: accepted push did not raise count");
`endif

endmodule

FILE: src/dfq_cell.sv
module dfq_cell
  import dfq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  dfq_cell_ctrl_t       ctrl,
  input  logic                 prev_valid,
  input  logic                 next_valid,
  input  logic [KEY_WIDTH-1:0] next_key,
  output logic                 valid,
  output logic [KEY_WIDTH-1:0] key,
  output logic                 match
);

  logic                 valid_r, valid_nxt;
  logic [KEY_WIDTH-1:0] key_r, key_nxt;
  logic                 load;

  // first empty cell takes the pushed key
  assign load = ctrl.push && prev_valid && !valid_r;

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    if (ctrl.pop) begin
      valid_nxt = next_valid;
      key_nxt   = next_key;
    end else if (load) begin
      valid_nxt = 1'b1;
      key_nxt   = ctrl.key;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign valid = valid_r;
  assign key   = key_r;
  assign match = valid_r && (key_r == ctrl.key);

endmodule

FILE: src/dfq_row.sv
module dfq_row
  import dfq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  dfq_cell_ctrl_t ctrl,
  output dfq_row_stat_t  stat
);

  logic [QUEUE_DEPTH-1:0] valid_vec;
  logic [QUEUE_DEPTH-1:0] match_vec;
  logic [KEY_WIDTH-1:0]   key_arr [QUEUE_DEPTH];

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                 prev_v;
    logic                 next_v;
    logic [KEY_WIDTH-1:0] next_k;

    if (i == 0) begin : g_first
      assign prev_v = 1'b1;
    end else begin : g_mid
      assign prev_v = valid_vec[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign next_v = 1'b0;
      assign next_k = '0;
    end else begin : g_inner
      assign next_v = valid_vec[i+1];
      assign next_k = key_arr[i+1];
    end

    dfq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .prev_valid (prev_v),
      .next_valid (next_v),
      .next_key   (next_k),
      .valid      (valid_vec[i]),
      .key        (key_arr[i]),
      .match      (match_vec[i])
    );
  end

  assign stat.dup          = |match_vec;
  assign stat.full         = valid_vec[QUEUE_DEPTH-1];
  assign stat.head_valid   = valid_vec[0];
  assign stat.head_key     = key_arr[0];
  assign stat.second_valid = valid_vec[1];
  assign stat.second_key   = key_arr[1];

`ifndef SYNTH
  // occupied cells always form an unbroken run from the head
  a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    ((valid_vec >> 1) & ~valid_vec) == '0)
    else $error("dfq_row: gap in occupied cells");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.push && !ctrl.pop && !valid_vec[QUEUE_DEPTH-1] |=>
      $countones(valid_vec) == $past($countones(valid_vec)) + 1)
    else $error("dfq_row: push did not add one entry");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.pop && valid_vec[0] |=>
      $countones(valid_vec) + 1 == $past($countones(valid_vec)))
    else $error("dfq_row: pop did not remove one entry");
`endif

endmodule

FILE: tb/tb_dedup_fifo_queue.sv
`timescale 1ns / 100ps

module tb_dedup_fifo_queue;
  import dfq_pkg::*;

  localparam int DEPTH      = QUEUE_DEPTH_DEF;
  localparam int PTR_W      = $clog2(DEPTH);
  localparam int RAND_ITEMS = 1225;
  localparam int IDLE_LIMIT = 1000;
  // receiver holds off this long once so the output slots and the input back up
  localparam int LONG_HOLD    = 80;
  localparam int LONG_HOLD_AT = 500;

  // one row of the directed table; fixed_res only used when typed is set
  typedef struct packed {
    logic     kind;
    logic [KEY_WIDTH-1:0] key;
    bit       typed;
    dfq_out_t fixed_res;
  } stim_row_t;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  dfq_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  dfq_out_t out_data;

  // shadow copy of the queue contents
  logic [KEY_WIDTH-1:0] fifo_keys [DEPTH];
  logic [PTR_W-1:0]     fifo_head;
  logic [PTR_W-1:0]     fifo_tail;
  logic [OCC_W-1:0]     fifo_count;

  // results still owed by the block, oldest first
  dfq_out_t pending_res_q[$];
  int       mismatches = 0;
  int       rx_count = 0;
  int       idle_cycles = 0;

  dedup_fifo_queue uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // applies one operation to the shadow queue and returns the status and head view
  function automatic dfq_out_t apply_op(input dfq_in_t op);
    dfq_out_t res;
    bit       found;
    found = 1'b0;
    res.status = ST_DONE;
    if (op.kind == OP_PUSH) begin
      // parallel compare over the occupied slots only
      for (int i = 0; i < int'(fifo_count); i++) begin
        if (fifo_keys[fifo_head + PTR_W'(i)] == op.key) found = 1'b1;
      end
      // duplicate check wins over the full check
      if (found) begin
        res.status = ST_DUP;
      end else if (int'(fifo_count) >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        fifo_keys[fifo_tail] = op.key;
        fifo_tail  = fifo_tail + 1'b1;
        fifo_count = fifo_count + 1'b1;
      end
    end else begin
      if (fifo_count == '0) begin
        res.status = ST_EMPTY;
      end else begin
        fifo_head  = fifo_head + 1'b1;
        fifo_count = fifo_count - 1'b1;
      end
    end
    res.head_valid = (fifo_count != '0);
    res.head_key   = res.head_valid ? fifo_keys[fifo_head] : '0;
    res.occupancy  = fifo_count;
    return res;
  endfunction

  function automatic stim_row_t mk_row(input logic kind, input logic [KEY_WIDTH-1:0] key,
                                       input bit typed, input dfq_out_t fixed_res);
    stim_row_t row;
    row.kind      = kind;
    row.key       = key;
    row.typed     = typed;
    row.fixed_res = fixed_res;
    return row;
  endfunction

  // offers one operation after a random gap and waits for its transfer
  task automatic send_op(input dfq_in_t op, input bit typed, input dfq_out_t fixed_res);
    int       gap;
    dfq_out_t res;
    gap = $urandom_range(0, 10);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= op;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // transfer taken at this edge: predict in acceptance order
    res = apply_op(op);
    pending_res_q.push_back(typed ? fixed_res : res);
  endtask

  // stimulus: reset, directed table, then random traffic
  initial begin
    stim_row_t rows[$];
    dfq_in_t   op;
    int        push_pct;
    int        pick;

    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    fifo_head  = '0;
    fifo_tail  = '0;
    fifo_count = '0;

    // directed table: empty pop, key extremes, duplicate, drain, fill to the brim
    rows.push_back(mk_row(OP_POP,  32'h0, 1'b1, '{ST_EMPTY, 1'b0, 32'h0, 5'd0}));
    rows.push_back(mk_row(OP_PUSH, 32'h0, 1'b1, '{ST_DONE,  1'b1, 32'h0, 5'd1}));
    rows.push_back(mk_row(OP_PUSH, 32'h0, 1'b1, '{ST_DUP,   1'b1, 32'h0, 5'd1}));
    rows.push_back(mk_row(OP_PUSH, 32'hFFFF_FFFF, 1'b1, '{ST_DONE, 1'b1, 32'h0, 5'd2}));
    // pop with a key on the bus: the key is ignored
    rows.push_back(mk_row(OP_POP,  32'hFFFF_FFFF, 1'b1,
                          '{ST_DONE, 1'b1, 32'hFFFF_FFFF, 5'd1}));
    rows.push_back(mk_row(OP_POP,  32'h0, 1'b1, '{ST_DONE,  1'b0, 32'h0, 5'd0}));
    rows.push_back(mk_row(OP_POP,  32'hFFFF_FFFF, 1'b1, '{ST_EMPTY, 1'b0, 32'h0, 5'd0}));
    for (int i = 0; i < DEPTH; i++) begin
      rows.push_back(mk_row(OP_PUSH, 32'h1 << i, 1'b0, '0));
    end
    // duplicate on a full queue reports the duplicate, not full
    rows.push_back(mk_row(OP_PUSH, 32'h1 << 7, 1'b1, '{ST_DUP,  1'b1, 32'h1, 5'd16}));
    rows.push_back(mk_row(OP_PUSH, 32'hDEAD_BEEF, 1'b1, '{ST_FULL, 1'b1, 32'h1, 5'd16}));

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) begin
      op.kind = rows[i].kind;
      op.key  = rows[i].key;
      send_op(op, rows[i].typed, rows[i].fixed_res);
    end

    // random traffic in phases of differing push bias so the queue swings
    // between empty and full
    for (int n = 0; n < RAND_ITEMS; n++) begin
      case ((n / 100) % 4)
        0:       push_pct = 50;
        1:       push_pct = 85;
        2:       push_pct = 25;
        default: push_pct = 60;
      endcase
      op.kind = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        // small pool of keys, so duplicates turn up often
        op.key = KEY_WIDTH'($urandom_range(0, 23));
      end else if (pick < 6 && fifo_count != '0) begin
        // a key that is queued right now, anywhere from head to tail
        op.key = fifo_keys[fifo_head + PTR_W'($urandom_range(0, int'(fifo_count) - 1))];
      end else begin
        op.key = $urandom;
      end
      send_op(op, 1'b0, '0);
    end

    @(negedge clk);
    in_valid <= 1'b0;

    // drain, then a few spare cycles for anything unexpected to show up
    while (pending_res_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // result side: random stall per result, one long hold-off
  initial begin
    int       hold;
    dfq_out_t want;
    dfq_out_t got;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      hold = (rx_count == LONG_HOLD_AT) ? LONG_HOLD : $urandom_range(0, 10);
      repeat (hold) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got = out_data;
      rx_count++;
      if (pending_res_q.size() == 0) begin
        $display("%0t: result with nothing owed, expected none actual %h", $time, got);
        mismatches++;
      end else begin
        want = pending_res_q.pop_front();
        if (got.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
          mismatches++;
        end
        if (got.head_valid !== want.head_valid) begin
          $display("%0t: head_valid expected %0b actual %0b", $time,
                   want.head_valid, got.head_valid);
          mismatches++;
        end
        if (got.head_key !== want.head_key) begin
          $display("%0t: head_key expected %h actual %h", $time, want.head_key, got.head_key);
          mismatches++;
        end
        if (got.occupancy !== want.occupancy) begin
          $display("%0t: occupancy expected %0d actual %0d", $time,
                   want.occupancy, got.occupancy);
          mismatches++;
        end
      end
    end
  end

  // watchdog: too many cycles without a transfer on either side ends the run
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("== FAIL ==");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
